@@ hw/rtl/ewzad_pkg.sv @@
// shared types and constants for the ewma z-score anomaly detector
`timescale 1ns / 1ps
`default_nettype none
package ewzad_pkg;

  localparam int SLOT_W = 6;
  localparam int VAR_W = 48;
  localparam int Z_W = 16;
  localparam int THR_W = 16;
  localparam int WARM_W = 3;
  localparam int Q_W = 17;

  localparam logic [13:0] ALPHA_NUM = 14'd13107;
  localparam logic [15:0] ONE_MINUS_ALPHA_NUM = 16'd52429;
  localparam logic [WARM_W-1:0] WARMUP_DONE = 3'd5;
  localparam logic [VAR_W-1:0] VAR_MAX = {VAR_W{1'b1}};
  localparam logic [THR_W-1:0] THRESHOLD_RESET = 16'd768;
  localparam logic [4:0] SQRT_LAST = 5'd31;
  localparam logic [4:0] DIV_FIRST = 5'd16;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_DIFF,
    ST_SQ,
    ST_VAR,
    ST_WRITE,
    ST_SQRT,
    ST_DINIT,
    ST_DIV,
    ST_DONE
  } back_st_t;

  typedef struct packed {
    logic              valid;
    logic              in_range;
    logic [SLOT_W-1:0] slot;
  } q_head_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } bk_status_t;

endpackage
`default_nettype wire

@@ hw/rtl/ewma_zscore_anomaly_detector.sv @@
// top level of the ewma z-score anomaly detector
`timescale 1ns / 1ps
`default_nettype none
// Per-slot EWMA z-score anomaly detector. Each input beat names a slot and brings a
// signed Q16.16 sample; one result beat comes back per input, in order. A front queue
// of two beats accepts input while the back engine works on one sample at a time.
// Taken from the queue, a sample still in warm-up goes through read, difference,
// square, variance and write-back before its result beat is loaded; a slot beyond
// the table goes straight to its result beat; a judged sample also passes the
// 32-step square root, a divider set-up state and the 17-step divider in the back
// engine. After reset a clearing pass zeroes all NUM_STREAMS slot entries; input is
// stalled until it ends. The user must write the threshold register through
// cfg_wen / cfg_wdata only while the block is idle; the block does not enforce this.
module ewma_zscore_anomaly_detector #(
  parameter int NUM_STREAMS = 64,
  parameter int SAMPLE_WIDTH = 32
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 cfg_wen,
  input  wire  [ewzad_pkg::THR_W-1:0]         cfg_wdata,
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  wire  [ewzad_pkg::SLOT_W-1:0]        stream_index,
  input  wire  signed [SAMPLE_WIDTH-1:0]      sample_value,
  output logic                                out_valid,
  input  wire                                 out_stall,
  output logic [ewzad_pkg::SLOT_W-1:0]        slot_echo,
  output logic                                judged,
  output logic                                anomaly_flag,
  output logic signed [ewzad_pkg::Z_W-1:0]    z_score
);

  logic [ewzad_pkg::THR_W-1:0] anomaly_threshold;
  ewzad_pkg::q_head_t          head;
  ewzad_pkg::bk_status_t       status;
  logic [SAMPLE_WIDTH-1:0]     head_sample;

  always_ff @(posedge clk) begin
    if (rst) begin
      anomaly_threshold <= ewzad_pkg::THRESHOLD_RESET;
    end else if (cfg_wen) begin
      anomaly_threshold <= cfg_wdata;
    end
  end

  ewzad_front #(
    .NUM_STREAMS (NUM_STREAMS),
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .stream_index(stream_index),
    .sample_value(sample_value),
    .status      (status),
    .head        (head),
    .head_sample (head_sample)
  );

  ewzad_back #(
    .NUM_STREAMS (NUM_STREAMS),
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .head_sample (head_sample),
    .status      (status),
    .threshold   (anomaly_threshold),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .slot_echo   (slot_echo),
    .judged      (judged),
    .anomaly_flag(anomaly_flag),
    .z_score     (z_score)
  );

endmodule
`default_nettype wire

@@ hw/rtl/ewzad_front.sv @@
// front end: input beat acceptance, slot range check and two-entry queue
`timescale 1ns / 1ps
`default_nettype none
module ewzad_front #(
  parameter int NUM_STREAMS = 64,
  parameter int SAMPLE_WIDTH = 32
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  wire  [ewzad_pkg::SLOT_W-1:0]        stream_index,
  input  wire  signed [SAMPLE_WIDTH-1:0]      sample_value,
  input  ewzad_pkg::bk_status_t               status,
  output ewzad_pkg::q_head_t                  head,
  output logic [SAMPLE_WIDTH-1:0]             head_sample
);

  logic [ewzad_pkg::SLOT_W-1:0] slot_q [2];
  logic [SAMPLE_WIDTH-1:0]      samp_q [2];
  logic                         rng_q  [2];
  logic [1:0] count;
  logic       wr_ptr;
  logic       rd_ptr;
  logic       accept;
  logic       in_range;

  assign in_range = 32'(stream_index) < 32'(NUM_STREAMS);
  assign in_stall = (count == 2'd2) || status.clearing;
  assign accept   = in_valid && !in_stall;

  assign head.valid    = count != 2'd0;
  assign head.in_range = rng_q[rd_ptr];
  assign head.slot     = slot_q[rd_ptr];
  assign head_sample   = samp_q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (accept) wr_ptr <= ~wr_ptr;
      if (status.pop) rd_ptr <= ~rd_ptr;
      case ({accept, status.pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slot_q[wr_ptr] <= stream_index;
      samp_q[wr_ptr] <= sample_value;
      rng_q[wr_ptr]  <= in_range;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/ewzad_back.sv @@
// back end: slot state memory, ewma update, iterative root and divide, result register
`timescale 1ns / 1ps
`default_nettype none
module ewzad_back #(
  parameter int NUM_STREAMS = 64,
  parameter int SAMPLE_WIDTH = 32
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  ewzad_pkg::q_head_t                   head,
  input  wire  [SAMPLE_WIDTH-1:0]              head_sample,
  output ewzad_pkg::bk_status_t                status,
  input  wire  [ewzad_pkg::THR_W-1:0]          threshold,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output logic [ewzad_pkg::SLOT_W-1:0]         slot_echo,
  output logic                                 judged,
  output logic                                 anomaly_flag,
  output logic signed [ewzad_pkg::Z_W-1:0]     z_score
);

  localparam int SW = SAMPLE_WIDTH;
  localparam int AW = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
  localparam int VW = ewzad_pkg::VAR_W;
  localparam int WW = ewzad_pkg::WARM_W;
  localparam int EW = WW + VW + SW;
  localparam int MW = SW + 1;
  localparam int CW = (SW + 9 > 49) ? SW + 9 : 49;
  localparam int QW = ewzad_pkg::Q_W;

  ewzad_pkg::back_st_t st, st_next;

  logic [EW-1:0] mem [NUM_STREAMS];
  logic [EW-1:0] rd_data;
  logic [EW-1:0] mem_wdata;
  logic [AW-1:0] mem_waddr;
  logic          mem_we;
  logic [AW-1:0] clr_addr;
  logic [AW-1:0] cur_addr;

  logic [ewzad_pkg::SLOT_W-1:0] cur_slot;
  logic [SW-1:0]  cur_sample;
  logic           cur_range;
  logic [SW-1:0]  mean;
  logic [VW-1:0]  var_old;
  logic [WW-1:0]  warm;
  logic [MW-1:0]  diff;
  logic [MW-1:0]  mag;
  logic           is_judged;
  logic [SW-1:0]  mean_new;
  logic [VW-1:0]  sq;
  logic [VW-1:0]  t_sat;

  logic [63:0]    sq_n;
  logic [33:0]    sq_rem;
  logic [31:0]    root;
  logic [4:0]     step;

  logic [CW-1:0]  drem;
  logic [CW-1:0]  dsh;
  logic [QW-1:0]  quo;
  logic           cap;

  logic           out_free;

  // combinational datapath pieces
  logic [MW-1:0]          diff_c;
  logic signed [SW+15:0]  mprod;
  logic signed [SW+15:0]  msum;
  logic [31:0]            mag32;
  logic                   over32;
  logic [63:0]            magsq;
  logic [61:0]            sprod;
  logic [VW:0]            tsum;
  logic [63:0]            vprod;
  logic [VW-1:0]          v1;
  logic [35:0]            sq_sh;
  logic [35:0]            sq_trial;
  logic [CW-1:0]          num;
  logic [WW-1:0]          warm_new;
  logic [ewzad_pkg::Z_W-1:0] z_c;
  logic                   flag_c;

  assign cur_addr = AW'(cur_slot);
  assign out_free = !out_valid || !out_stall;

  assign diff_c   = {cur_sample[SW-1], cur_sample} - {rd_data[SW-1], rd_data[SW-1:0]};
  assign mprod    = $signed(diff) * $signed({1'b0, ewzad_pkg::ALPHA_NUM});
  assign msum     = {{16{mean[SW-1]}}, mean} + (mprod >>> 16);
  assign mag32    = 32'(mag);
  assign over32   = |(mag >> 32);
  assign magsq    = mag32 * mag32;
  assign sprod    = sq * ewzad_pkg::ALPHA_NUM;
  assign tsum     = {1'b0, var_old} + {3'b0, sprod[61:16]};
  assign vprod    = t_sat * ewzad_pkg::ONE_MINUS_ALPHA_NUM;
  assign v1       = (var_old == '0) ? VW'(1) : var_old;
  assign sq_sh    = {sq_rem, sq_n[63:62]};
  assign sq_trial = {2'b00, root, 2'b01};
  assign num      = CW'(mag) << 8;
  assign warm_new = (warm < ewzad_pkg::WARMUP_DONE) ? warm + WW'(1) : warm;

  // saturated z and the flag on the unsaturated quotient
  always_comb begin
    flag_c = is_judged && (cap || (quo >= {1'b0, threshold}));
    if (!is_judged) begin
      z_c = '0;
    end else if (diff[MW-1]) begin
      z_c = (cap || quo > 17'd32768) ? 16'h8000 : 16'(17'd0 - quo);
    end else begin
      z_c = (cap || quo > 17'd32767) ? 16'h7fff : quo[15:0];
    end
  end

  // next state
  always_comb begin
    st_next = st;
    unique case (st)
      ewzad_pkg::ST_CLEAR: begin
        if (clr_addr == AW'(NUM_STREAMS - 1)) st_next = ewzad_pkg::ST_IDLE;
      end
      ewzad_pkg::ST_IDLE: begin
        if (head.valid) st_next = head.in_range ? ewzad_pkg::ST_READ : ewzad_pkg::ST_DONE;
      end
      ewzad_pkg::ST_READ:  st_next = ewzad_pkg::ST_DIFF;
      ewzad_pkg::ST_DIFF:  st_next = ewzad_pkg::ST_SQ;
      ewzad_pkg::ST_SQ:    st_next = ewzad_pkg::ST_VAR;
      ewzad_pkg::ST_VAR:   st_next = ewzad_pkg::ST_WRITE;
      ewzad_pkg::ST_WRITE: begin
        st_next = is_judged ? ewzad_pkg::ST_SQRT : ewzad_pkg::ST_DONE;
      end
      ewzad_pkg::ST_SQRT: begin
        if (step == ewzad_pkg::SQRT_LAST) st_next = ewzad_pkg::ST_DINIT;
      end
      ewzad_pkg::ST_DINIT: st_next = ewzad_pkg::ST_DIV;
      ewzad_pkg::ST_DIV: begin
        if (step == 5'd0) st_next = ewzad_pkg::ST_DONE;
      end
      ewzad_pkg::ST_DONE: begin
        if (out_free) st_next = ewzad_pkg::ST_IDLE;
      end
      default: st_next = ewzad_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    status.pop      = 1'b0;
    status.clearing = 1'b0;
    mem_we          = 1'b0;
    mem_waddr       = cur_addr;
    mem_wdata       = {warm_new, vprod[63:16], mean_new};
    unique case (st)
      ewzad_pkg::ST_CLEAR: begin
        status.clearing = 1'b1;
        mem_we          = 1'b1;
        mem_waddr       = clr_addr;
        mem_wdata       = '0;
      end
      ewzad_pkg::ST_IDLE:  status.pop = head.valid;
      ewzad_pkg::ST_WRITE: mem_we = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= ewzad_pkg::ST_CLEAR;
      clr_addr <= '0;
    end else begin
      st <= st_next;
      if (st == ewzad_pkg::ST_CLEAR) clr_addr <= clr_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (st == ewzad_pkg::ST_READ) rd_data <= mem[cur_addr];
  end

  always_ff @(posedge clk) begin
    case (st)
      ewzad_pkg::ST_IDLE: begin
        cur_slot   <= head.slot;
        cur_sample <= head_sample;
        cur_range  <= head.in_range;
        is_judged  <= 1'b0;
      end
      ewzad_pkg::ST_DIFF: begin
        mean      <= rd_data[SW-1:0];
        var_old   <= rd_data[SW+VW-1:SW];
        warm      <= rd_data[EW-1:SW+VW];
        is_judged <= rd_data[EW-1:SW+VW] >= ewzad_pkg::WARMUP_DONE;
        diff      <= diff_c;
        mag       <= diff_c[MW-1] ? MW'(0) - diff_c : diff_c;
      end
      ewzad_pkg::ST_SQ: begin
        mean_new <= msum[SW-1:0];
        sq       <= over32 ? ewzad_pkg::VAR_MAX : magsq[63:16];
      end
      ewzad_pkg::ST_VAR: begin
        t_sat <= tsum[VW] ? ewzad_pkg::VAR_MAX : tsum[VW-1:0];
      end
      ewzad_pkg::ST_WRITE: begin
        sq_n   <= {v1, 16'd0};
        sq_rem <= '0;
        root   <= '0;
        step   <= '0;
      end
      ewzad_pkg::ST_SQRT: begin
        // one result bit per cycle, two radicand bits consumed
        sq_n <= sq_n << 2;
        step <= step + 5'd1;
        if (sq_sh >= sq_trial) begin
          sq_rem <= 34'(sq_sh - sq_trial);
          root   <= {root[30:0], 1'b1};
        end else begin
          sq_rem <= sq_sh[33:0];
          root   <= {root[30:0], 1'b0};
        end
      end
      ewzad_pkg::ST_DINIT: begin
        drem <= num;
        dsh  <= CW'(root) << 16;
        cap  <= num >= (CW'(root) << 17);
        quo  <= '0;
        step <= ewzad_pkg::DIV_FIRST;
      end
      ewzad_pkg::ST_DIV: begin
        dsh  <= dsh >> 1;
        step <= step - 5'd1;
        if (drem >= dsh) begin
          drem <= drem - dsh;
          quo  <= {quo[QW-2:0], 1'b1};
        end else begin
          quo  <= {quo[QW-2:0], 1'b0};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (st == ewzad_pkg::ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st == ewzad_pkg::ST_DONE && out_free) begin
      slot_echo    <= cur_slot;
      judged       <= is_judged;
      anomaly_flag <= flag_c;
      z_score      <= z_c;
    end
  end

  a_unjudged_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !judged |-> z_score == '0 && !anomaly_flag)
    else $error("unjudged beat carries a z-score or flag");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    st == ewzad_pkg::ST_WRITE |-> cur_range)
    else $error("state write for a slot beyond the table");

  a_no_pop_clear: assert property (@(posedge clk) disable iff (rst)
    status.clearing |-> !status.pop)
    else $error("queue popped during clearing pass");

  a_root_floor: assert property (@(posedge clk) disable iff (rst)
    st == ewzad_pkg::ST_DINIT |-> root >= 32'd256)
    else $error("standard deviation below one variance lsb");

endmodule
`default_nettype wire

@@ bench/ewma_zscore_anomaly_detector_tb.sv @@
// self-checking testbench for the ewma z-score anomaly detector
`timescale 1ns / 1ps
`default_nettype none

class zscore_scoreboard;
  logic signed [63:0] mean_q [64];
  logic [63:0] var_q [64];
  int unsigned warm_cnt [64];
  logic [15:0] threshold;
  logic [5:0] exp_slot [$];
  logic exp_judged [$];
  logic exp_flag [$];
  logic [15:0] exp_z [$];
  int mismatches;

  function new();
    for (int i = 0; i < 64; i++) begin
      mean_q[i] = 0;
      var_q[i] = 0;
      warm_cnt[i] = 0;
    end
    threshold = ewzad_pkg::THRESHOLD_RESET;
    mismatches = 0;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // appends one expected result beat at the tail of the queues
  function void queue_expect(logic [5:0] slot, logic j, logic f, logic [15:0] z);
    exp_slot.insert(exp_slot.size(), slot);
    exp_judged.insert(exp_judged.size(), j);
    exp_flag.insert(exp_flag.size(), f);
    exp_z.insert(exp_z.size(), z);
  endfunction

  function void note_sample(logic [5:0] slot, logic signed [31:0] sample);
    logic signed [63:0] diff;
    logic signed [63:0] prod;
    logic [63:0] mag, v, sd, zq, sq, t, vmax;
    logic [15:0] zf;
    logic j, f;
    vmax = (64'd1 << 48) - 1;
    diff = 64'(sample) - mean_q[slot];
    mag = diff < 0 ? 64'(-diff) : 64'(diff);
    v = var_q[slot];
    j = 0;
    f = 0;
    zf = 0;
    if (warm_cnt[slot] >= 5) begin
      sd = int_sqrt((v == 0 ? 64'd1 : v) << 16);
      if (sd == 0) sd = 1;
      zq = (mag << 8) / sd;
      j = 1;
      f = zq >= 64'(threshold);
      if (diff < 0) zf = zq > 32768 ? 16'h8000 : 16'(-zq);
      else zf = zq > 32767 ? 16'h7fff : 16'(zq);
    end
    prod = diff * 64'sd13107;
    // floor division of a signed product
    if (prod >= 0) mean_q[slot] = mean_q[slot] + (prod >>> 16);
    else mean_q[slot] = mean_q[slot] - 64'((64'(-prod) + 65535) >> 16);
    if (mag >= (64'd1 << 32)) sq = vmax;
    else begin
      sq = (mag * mag) >> 16;
      if (sq > vmax) sq = vmax;
    end
    t = v + ((sq * 13107) >> 16);
    if (t > vmax) t = vmax;
    var_q[slot] = (t * 52429) >> 16;
    if (warm_cnt[slot] < 5) warm_cnt[slot]++;
    queue_expect(slot, j, f, zf);
  endfunction

  function void check_result(logic [5:0] slot, logic j, logic f, logic [15:0] z);
    logic [5:0] es;
    logic ej, ef;
    logic [15:0] ez;
    if (exp_slot.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result beat slot %0d", slot);
      return;
    end
    es = exp_slot.pop_front();
    ej = exp_judged.pop_front();
    ef = exp_flag.pop_front();
    ez = exp_z.pop_front();
    if (es !== slot || ej !== j || ef !== f || ez !== z) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: exp slot %0d j %0b f %0b z %h, got slot %0d j %0b f %0b z %h",
                 es, ej, ef, ez, slot, j, f, z);
    end
  endfunction

  function int pending();
    return exp_slot.size();
  endfunction
endclass

module ewma_zscore_anomaly_detector_tb;

  logic clk = 0;
  logic rst = 1;
  logic cfg_wen = 0;
  logic [ewzad_pkg::THR_W-1:0] cfg_wdata = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [ewzad_pkg::SLOT_W-1:0] stream_index = 0;
  logic signed [31:0] sample_value = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [ewzad_pkg::SLOT_W-1:0] slot_echo;
  logic judged;
  logic anomaly_flag;
  logic signed [ewzad_pkg::Z_W-1:0] z_score;

  zscore_scoreboard board;
  int cycles = 0;
  bit stall_hold = 0;
  int stall_mode = 0;

  always #5 clk = ~clk;

  ewma_zscore_anomaly_detector u_dut (
    .clk(clk), .rst(rst), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .stream_index(stream_index),
    .sample_value(sample_value), .out_valid(out_valid), .out_stall(out_stall),
    .slot_echo(slot_echo), .judged(judged), .anomaly_flag(anomaly_flag),
    .z_score(z_score)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("FAIL ewma_zscore_anomaly_detector");
      $finish;
    end
    if (!rst && out_valid && !out_stall)
      board.check_result(slot_echo, judged, anomaly_flag, z_score);
  end

  // receiver stall pattern, switching at random among four styles
  always @(negedge clk) begin
    if (cycles % 300 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ((cycles / 7) % 3 == 0);
      default: out_stall <= ($urandom_range(0, 1) == 1);
    endcase
  end

  task automatic send_sample(logic [5:0] slot, logic signed [31:0] val);
    @(negedge clk);
    in_valid <= 1;
    stream_index <= slot;
    sample_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_sample(slot, val);
  endtask

  task automatic drop_valid();
    @(negedge clk);
    in_valid <= 0;
  endtask

  task automatic wait_drained();
    drop_valid();
    while (board.pending() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_threshold(logic [15:0] thr);
    @(negedge clk);
    cfg_wen <= 1;
    cfg_wdata <= thr;
    @(negedge clk);
    cfg_wen <= 0;
    board.threshold = thr;
  endtask

  function automatic logic signed [31:0] rand_sample(logic signed [31:0] base, int spread);
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return 32'sh7fffffff;
      2: return 32'sh80000000;
      default: return base + $signed($urandom_range(0, 2 * spread)) - spread;
    endcase
  endfunction

  task automatic random_phase(int count);
    int sent;
    int burst;
    logic [5:0] slot;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 20);
      repeat (burst) begin
        // a handful of hot slots so most reach warm-up
        slot = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 7));
        send_sample(slot, rand_sample(32'sh00010000 * $signed(32'(slot)),
                    $urandom_range(1, 1 << $urandom_range(4, 20))));
        sent++;
      end
      if ($urandom_range(0, 2) != 0) begin
        drop_valid();
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  endtask

  initial begin
    board = new();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: warm a slot on a constant, then extremes and zero variance
    for (int i = 0; i < 6; i++) send_sample(0, 32'sh00010000);
    send_sample(0, 32'sh00010000);
    send_sample(0, 32'sh00010001);
    send_sample(0, 32'sh7fffffff);
    send_sample(0, 32'sh80000000);
    send_sample(63, 32'sh80000000);
    send_sample(63, 32'sh7fffffff);
    for (int i = 0; i < 6; i++) send_sample(1, -32'sh00001000 * i);
    send_sample(1, 32'sh00100000);
    wait_drained();

    write_threshold(16'h0000);
    for (int i = 0; i < 4; i++) send_sample(1, 32'sh00000100 * i);
    wait_drained();
    write_threshold(16'hffff);
    random_phase(250);
    wait_drained();
    write_threshold(16'h0100);
    random_phase(250);
    wait_drained();
    write_threshold(16'($urandom));
    random_phase(250);
    wait_drained();
    write_threshold(ewzad_pkg::THRESHOLD_RESET);
    random_phase(270);
    wait_drained();

    if (board.mismatches == 0)
      $display("PASS ewma_zscore_anomaly_detector");
    else
      $display("FAIL ewma_zscore_anomaly_detector");
    $finish;
  end
endmodule
`default_nettype wire

@@ files.f @@
hw/rtl/ewzad_pkg.sv
hw/rtl/ewzad_front.sv
hw/rtl/ewzad_back.sv
hw/rtl/ewma_zscore_anomaly_detector.sv
bench/ewma_zscore_anomaly_detector_tb.sv
